FILE: hw/rtl/jws_pkg.sv
`default_nettype none
package jws_pkg;

	localparam int unsigned WEIGHT_W = 17;
	localparam logic [16:0] ONE_Q16  = 17'h10000;

	localparam logic [2:0] CFG_WEIGHT_A    = 3'd0;
	localparam logic [2:0] CFG_WEIGHT_B    = 3'd1;
	localparam logic [2:0] CFG_WEIGHT_T    = 3'd2;
	localparam logic [2:0] CFG_THRESHOLD   = 3'd3;
	localparam logic [2:0] CFG_SCALE       = 3'd4;
	localparam logic [2:0] CFG_PREFIX_LIM  = 3'd5;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLR,
		OP_MI,
		OP_MSTEP,
		OP_TINIT,
		OP_TSKIPI,
		OP_TSKIPK,
		OP_TCMP,
		OP_MUL,
		OP_DSTART,
		OP_ACC,
		OP_SAT,
		OP_PSTEP,
		OP_BM1,
		OP_BM2,
		OP_BADD,
		OP_OUT
	} dp_op_t;

	typedef enum logic [1:0] {
		DIV_A,
		DIV_B,
		DIV_T
	} div_sel_t;

	typedef struct packed {
		dp_op_t   op;
		div_sel_t sel;
		logic     b_from_i;
	} cmd_t;

	typedef struct packed {
		logic str_empty;
		logic i_eq_la;
		logic win_empty;
		logic m_zero;
		logic hit;
		logic j_last;
		logic am_i;
		logic j_eq_lb;
		logic bm_j;
		logic div_done;
		logic boost_ok;
		logic i_eq_lim;
		logic chars_eq;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/jws_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle
module jws_div #(
	parameter int unsigned NW = 24,
	parameter int unsigned DW = 7
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic      [NW-1:0] quo,
	output logic               done
);
	localparam int unsigned CW = $clog2(NW + 1);

	logic [NW-1:0] n_q;
	logic [DW-1:0] r_q;
	logic [DW-1:0] d_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   rs;
	logic          ge;

	assign rs = {r_q, n_q[NW-1]};
	assign ge = rs >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (cnt_q == CW'(NW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			d_q <= den;
			r_q <= '0;
		end else if (busy_q) begin
			r_q <= ge ? DW'(rs - {1'b0, d_q}) : rs[DW-1:0];
			n_q <= {n_q[NW-2:0], ge};
		end
	end

	assign quo  = n_q;
	assign done = done_q;
endmodule
`default_nettype wire

FILE: hw/rtl/jws_dp.sv
`default_nettype none
module jws_dp import jws_pkg::*; #(
	parameter int unsigned MAX_LEN = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [16:0] cfg_data,
	input  wire logic        in_accept,
	input  wire logic        in_which,
	input  wire logic [7:0]  in_char,
	input  wire logic        in_cvalid,
	input  wire cmd_t        cmd,
	output sts_t             sts,
	input  wire logic        out_ready,
	output logic             out_valid,
	output logic [16:0]      out_sim,
	output logic [6:0]       out_m,
	output logic [6:0]       out_t,
	output logic [3:0]       out_pfx,
	output logic             out_long
);
	localparam int unsigned LW = $clog2(MAX_LEN + 1);
	localparam int unsigned AW = $clog2(MAX_LEN);
	localparam int unsigned NW = WEIGHT_W + LW;
	localparam int unsigned SW = NW + 2;
	localparam int unsigned PW = (LW > 4) ? LW : 4;

	// configuration
	logic [16:0] wa_q, wb_q, wt_q, thr_q, scale_q;
	logic [3:0]  plim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wa_q    <= 17'd21845;
			wb_q    <= 17'd21845;
			wt_q    <= 17'd21845;
			thr_q   <= 17'd45875;
			scale_q <= 17'd6554;
			plim_q  <= 4'd4;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WEIGHT_A:   wa_q    <= cfg_data;
				CFG_WEIGHT_B:   wb_q    <= cfg_data;
				CFG_WEIGHT_T:   wt_q    <= cfg_data;
				CFG_THRESHOLD:  thr_q   <= cfg_data;
				CFG_SCALE:      scale_q <= cfg_data;
				CFG_PREFIX_LIM: plim_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// string buffers
	logic [7:0]    a_mem [MAX_LEN];
	logic [7:0]    b_mem [MAX_LEN];
	logic [7:0]    a_rd_q, b_rd_q;
	logic [LW-1:0] la_q, lb_q;
	logic          ovf_q;
	logic          wr_a, wr_b;
	logic [LW-1:0] i_q, j_q;
	logic [LW-1:0] b_addr;

	assign wr_a = in_accept && in_cvalid && !in_which && (la_q < LW'(MAX_LEN));
	assign wr_b = in_accept && in_cvalid &&  in_which && (lb_q < LW'(MAX_LEN));
	assign b_addr = cmd.b_from_i ? i_q : j_q;

	always_ff @(posedge clk) begin
		if (wr_a)
			a_mem[la_q[AW-1:0]] <= in_char;
		a_rd_q <= a_mem[i_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (wr_b)
			b_mem[lb_q[AW-1:0]] <= in_char;
		b_rd_q <= b_mem[b_addr[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			la_q  <= '0;
			lb_q  <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.op == OP_OUT) begin
			la_q  <= '0;
			lb_q  <= '0;
			ovf_q <= 1'b0;
		end else if (in_accept && in_cvalid) begin
			if (wr_a)
				la_q <= la_q + LW'(1);
			else if (wr_b)
				lb_q <= lb_q + LW'(1);
			else
				ovf_q <= 1'b1;
		end
	end

	// match window
	logic [LW-1:0] wmax, whalf, win_q;
	logic [LW-1:0] lo;
	logic [LW:0]   hi_full, hi;
	logic [LW:0]   hi_q;
	logic [MAX_LEN-1:0] am_q, bm_q;
	logic [LW-1:0] m_q, t_q;

	assign wmax    = (la_q > lb_q) ? la_q : lb_q;
	assign whalf   = wmax >> 1;
	assign lo      = (i_q > win_q) ? i_q - win_q : '0;
	assign hi_full = {1'b0, i_q} + {1'b0, win_q} + (LW+1)'(1);
	assign hi      = (hi_full > {1'b0, lb_q}) ? {1'b0, lb_q} : hi_full;

	// arithmetic
	logic [NW-1:0] prod_q;
	logic [SW-1:0] score_q;
	logic [3:0]    pfx_q;
	logic [20:0]   sp_q;
	logic [37:0]   bp_q;
	logic [16:0]   mult_w;
	logic [LW-1:0] mult_n;
	logic [LW-1:0] den;
	logic [NW-1:0] quo;
	logic          div_done;
	logic [16:0]   score17;
	logic [22:0]   boosted;
	logic [PW-1:0] lim;
	logic [PW-1:0] lab_min;

	always_comb begin
		case (cmd.sel)
			DIV_A: begin
				mult_w = wa_q;
				mult_n = m_q;
				den    = la_q;
			end
			DIV_B: begin
				mult_w = wb_q;
				mult_n = m_q;
				den    = lb_q;
			end
			default: begin
				mult_w = wt_q;
				mult_n = m_q - (t_q >> 1);
				den    = m_q;
			end
		endcase
	end

	jws_div #(.NW(NW), .DW(LW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.op == OP_DSTART),
		.num    (prod_q),
		.den    (den),
		.quo    (quo),
		.done   (div_done)
	);

	assign score17 = score_q[16:0];
	assign boosted = 23'(score17) + 23'(bp_q[37:16]);
	assign lab_min = (la_q < lb_q) ? PW'(la_q) : PW'(lb_q);
	assign lim     = (lab_min > PW'(plim_q)) ? PW'(plim_q) : lab_min;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			am_q <= '0;
			bm_q <= '0;
		end else begin
			case (cmd.op)
				OP_CLR: begin
					am_q <= '0;
					bm_q <= '0;
				end
				OP_MSTEP: begin
					if (!bm_q[j_q[AW-1:0]] && (a_rd_q == b_rd_q)) begin
						am_q[i_q[AW-1:0]] <= 1'b1;
						bm_q[j_q[AW-1:0]] <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CLR: begin
				i_q     <= '0;
				j_q     <= '0;
				m_q     <= '0;
				t_q     <= '0;
				pfx_q   <= '0;
				score_q <= '0;
				win_q   <= (whalf == '0) ? '0 : whalf - LW'(1);
			end
			OP_MI: begin
				j_q  <= lo;
				hi_q <= hi;
			end
			OP_MSTEP: begin
				if (!bm_q[j_q[AW-1:0]] && (a_rd_q == b_rd_q)) begin
					m_q <= m_q + LW'(1);
					i_q <= i_q + LW'(1);
				end else if ({1'b0, j_q} + (LW+1)'(1) == hi_q) begin
					i_q <= i_q + LW'(1);
				end else begin
					j_q <= j_q + LW'(1);
				end
			end
			OP_TINIT: begin
				i_q <= '0;
				j_q <= '0;
			end
			OP_TSKIPI: i_q <= i_q + LW'(1);
			OP_TSKIPK: j_q <= j_q + LW'(1);
			OP_TCMP: begin
				if (a_rd_q != b_rd_q)
					t_q <= t_q + LW'(1);
				i_q <= i_q + LW'(1);
				j_q <= j_q + LW'(1);
			end
			OP_MUL: prod_q <= NW'(mult_w) * NW'(mult_n);
			OP_ACC: score_q <= score_q + SW'(quo);
			OP_SAT: begin
				if (score_q > SW'(ONE_Q16))
					score_q <= SW'(ONE_Q16);
				i_q <= '0;
			end
			OP_PSTEP: i_q <= i_q + LW'(1);
			OP_BM1: begin
				pfx_q <= 4'(i_q);
				sp_q  <= 21'(scale_q) * 21'(i_q[3:0]);
			end
			OP_BM2: bp_q <= 38'(sp_q) * 38'(ONE_Q16 - score17);
			OP_BADD: score_q <= (boosted > 23'(ONE_Q16)) ? SW'(ONE_Q16) : SW'(boosted);
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (cmd.op == OP_OUT)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_OUT) begin
			out_sim  <= score17;
			out_m    <= 7'(m_q);
			out_t    <= 7'(t_q);
			out_pfx  <= pfx_q;
			out_long <= ovf_q;
		end
	end

	assign sts.str_empty = (la_q == '0) || (lb_q == '0);
	assign sts.i_eq_la   = (i_q == la_q);
	assign sts.win_empty = ({1'b0, lo} >= hi);
	assign sts.m_zero    = (m_q == '0);
	assign sts.hit       = !bm_q[j_q[AW-1:0]] && (a_rd_q == b_rd_q);
	assign sts.j_last    = ({1'b0, j_q} + (LW+1)'(1) == hi_q);
	assign sts.am_i      = am_q[i_q[AW-1:0]];
	assign sts.j_eq_lb   = (j_q == lb_q);
	assign sts.bm_j      = bm_q[j_q[AW-1:0]];
	assign sts.div_done  = div_done;
	assign sts.boost_ok  = (score_q > SW'(thr_q));
	assign sts.i_eq_lim  = (PW'(i_q) == lim);
	assign sts.chars_eq  = (a_rd_q == b_rd_q);
	assign sts.out_free  = !out_valid || out_ready;
endmodule
`default_nettype wire

FILE: hw/rtl/jws_ctrl.sv
`default_nettype none
module jws_ctrl import jws_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_accept,
	input  wire logic in_last,
	input  wire sts_t sts,
	output cmd_t      cmd,
	output logic      in_ready
);
	typedef enum logic [19:0] {
		S_IDLE = 20'h00001,
		S_CLR  = 20'h00002,
		S_MI   = 20'h00004,
		S_MRD  = 20'h00008,
		S_MCMP = 20'h00010,
		S_TA   = 20'h00020,
		S_TK   = 20'h00040,
		S_TRD  = 20'h00080,
		S_TCMP = 20'h00100,
		S_MUL  = 20'h00200,
		S_DST  = 20'h00400,
		S_DWT  = 20'h00800,
		S_SAT  = 20'h01000,
		S_BCHK = 20'h02000,
		S_PRD  = 20'h04000,
		S_PCMP = 20'h08000,
		S_BM1  = 20'h10000,
		S_BM2  = 20'h20000,
		S_BADD = 20'h40000,
		S_OUT  = 20'h80000
	} state_t;

	state_t   state_q, state_d;
	div_sel_t sel_q, sel_d;

	always_comb begin
		state_d      = state_q;
		sel_d        = sel_q;
		in_ready     = 1'b0;
		cmd.op       = OP_NONE;
		cmd.sel      = sel_q;
		cmd.b_from_i = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_accept && in_last)
					state_d = S_CLR;
			end
			S_CLR: begin
				cmd.op  = OP_CLR;
				sel_d   = DIV_A;
				state_d = sts.str_empty ? S_OUT : S_MI;
			end
			S_MI: begin
				if (sts.i_eq_la || sts.win_empty) begin
					if (sts.m_zero) begin
						state_d = S_OUT;
					end else begin
						cmd.op  = OP_TINIT;
						state_d = S_TA;
					end
				end else begin
					cmd.op  = OP_MI;
					state_d = S_MRD;
				end
			end
			S_MRD: state_d = S_MCMP;
			S_MCMP: begin
				cmd.op  = OP_MSTEP;
				state_d = (sts.hit || sts.j_last) ? S_MI : S_MRD;
			end
			// walk matched characters of both strings in order
			S_TA: begin
				if (sts.i_eq_la) begin
					state_d = S_MUL;
				end else if (!sts.am_i) begin
					cmd.op = OP_TSKIPI;
				end else begin
					state_d = S_TK;
				end
			end
			S_TK: begin
				if (sts.j_eq_lb) begin
					cmd.op  = OP_TSKIPI;
					state_d = S_TA;
				end else if (!sts.bm_j) begin
					cmd.op = OP_TSKIPK;
				end else begin
					state_d = S_TRD;
				end
			end
			S_TRD: state_d = S_TCMP;
			S_TCMP: begin
				cmd.op  = OP_TCMP;
				state_d = S_TA;
			end
			S_MUL: begin
				cmd.op  = OP_MUL;
				state_d = S_DST;
			end
			S_DST: begin
				cmd.op  = OP_DSTART;
				state_d = S_DWT;
			end
			S_DWT: begin
				if (sts.div_done) begin
					cmd.op = OP_ACC;
					case (sel_q)
						DIV_A: begin
							sel_d   = DIV_B;
							state_d = S_MUL;
						end
						DIV_B: begin
							sel_d   = DIV_T;
							state_d = S_MUL;
						end
						default: state_d = S_SAT;
					endcase
				end
			end
			S_SAT: begin
				cmd.op  = OP_SAT;
				state_d = S_BCHK;
			end
			S_BCHK: state_d = sts.boost_ok ? S_PRD : S_OUT;
			S_PRD: begin
				cmd.b_from_i = 1'b1;
				state_d = sts.i_eq_lim ? S_BM1 : S_PCMP;
			end
			S_PCMP: begin
				if (sts.chars_eq) begin
					cmd.op  = OP_PSTEP;
					state_d = S_PRD;
				end else begin
					state_d = S_BM1;
				end
			end
			S_BM1: begin
				cmd.op  = OP_BM1;
				state_d = S_BM2;
			end
			S_BM2: begin
				cmd.op  = OP_BM2;
				state_d = S_BADD;
			end
			S_BADD: begin
				cmd.op  = OP_BADD;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.op  = OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q   <= DIV_A;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/jaro_winkler_similarity.sv
`default_nettype none
// channel | dir | tdata                          | tuser                     | tlast
// s_*     | in  | char_code                      | which_string, char_valid  | end_of_pair
// m_*     | out | similarity, match_count,       | too_long                  | -
//         |     | transposition_count, prefix    |                           |
// cfg_*   | in  | write port, index = register number, no read-back
//
// Character items load at one per cycle while the block is idle. An end-of-pair item
// holds the input through window matching, the transposition walk, three
// multiply-and-divide passes and, when the score passes the threshold, a prefix
// scan and the boost steps. Reset clears lengths and flags and loads the default
// configuration. A result that waits for m_tready does not block loading of the
// next pair; only the output of the next result waits.
module jaro_winkler_similarity import jws_pkg::*; #(
	parameter int unsigned MAX_LEN = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] char_code
	input  wire logic [1:0]  s_tuser,   // [0] which_string, [1] char_valid
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // [16:0] similarity, [23:17] match_count,
	                                    // [30:24] transposition_count, [34:31] prefix
	output logic [0:0]       m_tuser,   // [0] too_long
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [16:0] cfg_data
);
	cmd_t        cmd;
	sts_t        sts;
	logic        in_accept;
	logic [16:0] sim;
	logic [6:0]  mc, tc;
	logic [3:0]  pfx;
	logic        long_flag;

	assign in_accept = s_tvalid && s_tready;

	jws_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.in_last   (s_tlast),
		.sts       (sts),
		.cmd       (cmd),
		.in_ready  (s_tready)
	);

	jws_dp #(.MAX_LEN(MAX_LEN)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_accept (in_accept),
		.in_which  (s_tuser[0]),
		.in_char   (s_tdata),
		.in_cvalid (s_tuser[1]),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_sim   (sim),
		.out_m     (mc),
		.out_t     (tc),
		.out_pfx   (pfx),
		.out_long  (long_flag)
	);

	assign m_tdata = {5'b0, pfx, tc, mc, sim};
	assign m_tuser = long_flag;

	a_no_accept_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> !s_tready)
		else $error("input accepted while pair is computed");

	a_sim_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (sim <= ONE_Q16))
		else $error("similarity above one");

	a_zero_match: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && mc == 7'd0 && MAX_LEN < 128) |-> (sim == 17'd0 && pfx == 4'd0 && tc == 7'd0))
		else $error("nonzero result without matches");

	a_trans_le_match: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && MAX_LEN < 128) |-> (tc <= mc))
		else $error("more transpositions than matches");
endmodule
`default_nettype wire

FILE: sim/tb_jaro_winkler_similarity.sv
`default_nettype none
module tb_jaro_winkler_similarity import jws_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAX_LEN = 64;
	localparam logic [2:0]  CFG_UNUSED = 3'd7;

	typedef struct packed {
		logic       which;
		logic [7:0] code;
		logic       valid;
		logic       eop;
	} char_item_t;

	typedef struct packed {
		logic [16:0] sim;
		logic [6:0]  m_cnt;
		logic [6:0]  transp;
		logic [3:0]  prefix;
		logic        too_long;
	} score_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        s_tlast = 0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [39:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        cfg_we = 0;
	logic [2:0]  cfg_index = '0;
	logic [16:0] cfg_data = '0;

	jaro_winkler_similarity #(.MAX_LEN(MAX_LEN)) uut (.*);

	always #5 clk = ~clk;

	// predictor state
	logic [16:0] wa, wb, wt, thr, scl;
	logic [3:0]  plim;
	logic [7:0]  str_a [MAX_LEN];
	logic [7:0]  str_b [MAX_LEN];
	int unsigned len_a, len_b;
	bit          ovf;

	char_item_t  pending_chars[$];
	score_t      expected_scores[$];
	int          mismatches = 0;
	bit          no_idle = 0;
	bit          hold_off = 0;
	// accepted flag sampled at the rising edge
	logic        s_tready_q = 0;

	function automatic score_t score_pair();
		score_t r;
		bit ma [MAX_LEN];
		bit mb [MAX_LEN];
		int win, lo, hi, k;
		longint unsigned m, t, sc, p, lim;
		m = 0; t = 0; sc = 0; p = 0;
		for (int i = 0; i < MAX_LEN; i++) begin
			ma[i] = 0; mb[i] = 0;
		end
		if (len_a != 0 && len_b != 0) begin
			win = int'((len_a > len_b ? len_a : len_b) / 2) - 1;
			if (win < 0) win = 0;
			for (int i = 0; i < len_a; i++) begin
				lo = i - win;
				hi = i + win + 1;
				if (lo < 0) lo = 0;
				if (hi > int'(len_b)) hi = len_b;
				if (lo >= hi) break;
				for (int j = lo; j < hi; j++) begin
					if (!mb[j] && str_a[i] == str_b[j]) begin
						ma[i] = 1; mb[j] = 1; m++;
						break;
					end
				end
			end
			if (m != 0) begin
				k = 0;
				for (int i = 0; i < len_a; i++) begin
					if (ma[i]) begin
						while (k < len_b && !mb[k]) k++;
						if (k < len_b) begin
							if (str_a[i] != str_b[k]) t++;
							k++;
						end
					end
				end
				sc = longint'(wa) * m / len_a + longint'(wb) * m / len_b
					+ longint'(wt) * (m - t / 2) / m;
			end else begin
				t = 0;
			end
		end
		if (sc > 65536) sc = 65536;
		if (sc > thr) begin
			lim = len_a < len_b ? len_a : len_b;
			if (lim > plim) lim = plim;
			for (int i = 0; i < lim; i++) begin
				if (str_a[i] != str_b[i]) break;
				p++;
			end
			sc = sc + ((longint'(scl) * p * (65536 - sc)) >> 16);
			if (sc > 65536) sc = 65536;
		end
		r.sim = sc[16:0];
		r.m_cnt = m[6:0];
		r.transp = t[6:0];
		r.prefix = p[3:0];
		r.too_long = ovf;
		return r;
	endfunction

	function automatic void absorb_char(char_item_t it);
		if (it.valid) begin
			if (!it.which) begin
				if (len_a < MAX_LEN) begin str_a[len_a] = it.code; len_a++; end
				else ovf = 1;
			end else begin
				if (len_b < MAX_LEN) begin str_b[len_b] = it.code; len_b++; end
				else ovf = 1;
			end
		end
		if (it.eop) begin
			expected_scores.push_back(score_pair());
			len_a = 0; len_b = 0; ovf = 0;
		end
	endfunction

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || s_tready_q) begin
				if (pending_chars.size() > 0 && !hold_off
						&& (no_idle || $urandom_range(99) >= 27)) begin
					char_item_t it;
					it = pending_chars.pop_front();
					s_tvalid <= 1;
					s_tdata <= it.code;
					s_tuser <= {it.valid, it.which};
					s_tlast <= it.eop;
				end else begin
					s_tvalid <= 0;
				end
			end
			m_tready <= no_idle || ($urandom_range(99) >= 27);
		end
	end

	always @(posedge clk) begin
		s_tready_q <= s_tvalid && s_tready;
		if (s_tvalid && s_tready)
			absorb_char('{which: s_tuser[0], code: s_tdata, valid: s_tuser[1],
				eop: s_tlast});
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			score_t got, want;
			got.sim = m_tdata[16:0];
			got.m_cnt = m_tdata[23:17];
			got.transp = m_tdata[30:24];
			got.prefix = m_tdata[34:31];
			got.too_long = m_tuser[0];
			if (expected_scores.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", got);
			end else begin
				want = expected_scores.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"result mismatch: exp sim %0d m %0d t %0d p %0d tl %0d,",
							" got sim %0d m %0d t %0d p %0d tl %0d"},
							want.sim, want.m_cnt, want.transp, want.prefix,
							want.too_long, got.sim, got.m_cnt, got.transp,
							got.prefix, got.too_long);
				end
			end
		end
	end

	task automatic add_char(bit w, logic [7:0] c);
		pending_chars.push_back('{which: w, code: c, valid: 1'b1, eop: 1'b0});
	endtask

	task automatic add_end(bit w, logic [7:0] c, bit v);
		pending_chars.push_back('{which: w, code: c, valid: v, eop: 1'b1});
	endtask

	task automatic add_string(bit w, string s);
		for (int i = 0; i < s.len(); i++) add_char(w, s[i]);
	endtask

	// random pair: related strings so matches, transpositions and prefixes happen
	task automatic add_random_pair(int maxlen);
		int la, lb, alpha;
		logic [7:0] a [MAX_LEN + 4];
		logic [7:0] c;
		la = $urandom_range(maxlen);
		lb = $urandom_range(maxlen);
		alpha = $urandom_range(3) == 0 ? 256 : $urandom_range(2, 8);
		for (int i = 0; i < la; i++) begin
			a[i] = alpha == 256 ? 8'($urandom) : 8'(8'h61 + $urandom_range(alpha - 1));
			add_char(1'b0, a[i]);
			if ($urandom_range(15) == 0)
				pending_chars.push_back('{which: 1'($urandom), code: 8'($urandom),
					valid: 1'b0, eop: 1'b0});
		end
		for (int i = 0; i < lb; i++) begin
			if (i < la && $urandom_range(3) != 0) c = a[i];
			else if (la > 0 && $urandom_range(1)) c = a[$urandom_range(la - 1)];
			else c = 8'($urandom);
			if ($urandom_range(9) == 0 && i > 0 && i < la) c = a[i - 1];
			add_char(1'b1, c);
		end
		if ($urandom_range(4) == 0)
			add_end(1'($urandom), 8'($urandom), 1'b1);
		else
			add_end(1'($urandom), 8'($urandom), 1'b0);
	endtask

	task automatic wait_drained();
		while (pending_chars.size() > 0 || s_tvalid) @(posedge clk);
		while (expected_scores.size() > 0) @(posedge clk);
		repeat (3000) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [16:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		case (idx)
			CFG_WEIGHT_A:   wa = val;
			CFG_WEIGHT_B:   wb = val;
			CFG_WEIGHT_T:   wt = val;
			CFG_THRESHOLD:  thr = val;
			CFG_SCALE:      scl = val;
			CFG_PREFIX_LIM: plim = val[3:0];
			default: ;
		endcase
	endtask

	initial begin
		wa = 21845; wb = 21845; wt = 21845; thr = 45875; scl = 6554; plim = 4;
		len_a = 0; len_b = 0; ovf = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: classic pairs, empty strings, no match, one char, overflow
		add_string(1'b0, "MARTHA"); add_string(1'b1, "MARHTA"); add_end(1'b0, 8'h00, 1'b0);
		add_string(1'b0, "DIXON"); add_string(1'b1, "DICKSONX"); add_end(1'b0, 8'h00, 1'b0);
		add_end(1'b0, 8'h00, 1'b0);
		add_string(1'b0, "ABC"); add_end(1'b0, 8'h00, 1'b0);
		add_string(1'b0, "ABC"); add_string(1'b1, "XYZ"); add_end(1'b0, 8'h00, 1'b0);
		add_char(1'b0, 8'hff); add_end(1'b1, 8'h00, 1'b1);
		add_char(1'b0, 8'h00); add_end(1'b1, 8'h00, 1'b1);
		for (int i = 0; i < MAX_LEN + 2; i++) add_char(1'b0, 8'(8'h41 + i % 7));
		for (int i = 0; i < MAX_LEN + 1; i++) add_char(1'b1, 8'(8'h41 + i % 5));
		add_end(1'b1, 8'h41, 1'b1);
		wait_drained();

		// extremes of the registers
		write_reg(CFG_WEIGHT_A, 17'h10000);
		write_reg(CFG_WEIGHT_B, 17'h1ffff);
		write_reg(CFG_WEIGHT_T, 17'd0);
		write_reg(CFG_THRESHOLD, 17'd0);
		write_reg(CFG_SCALE, 17'h1ffff);
		write_reg(CFG_PREFIX_LIM, 17'd15);
		write_reg(CFG_UNUSED, 17'h1ffff);
		for (int i = 0; i < 20; i++) add_random_pair(20);
		wait_drained();

		write_reg(CFG_WEIGHT_A, 17'd0);
		write_reg(CFG_WEIGHT_B, 17'd0);
		write_reg(CFG_WEIGHT_T, 17'h10000);
		write_reg(CFG_THRESHOLD, 17'h10000);
		write_reg(CFG_SCALE, 17'd0);
		write_reg(CFG_PREFIX_LIM, 17'd0);
		for (int i = 0; i < 16; i++) add_random_pair(16);
		// pause sender until everything is back
		hold_off = 1;
		while (expected_scores.size() > 0 || s_tvalid) @(posedge clk);
		hold_off = 0;
		wait_drained();

		for (int ph = 0; ph < 3; ph++) begin
			write_reg(CFG_WEIGHT_A, 17'($urandom_range(65536)));
			write_reg(CFG_WEIGHT_B, 17'($urandom_range(65536)));
			write_reg(CFG_WEIGHT_T, 17'($urandom_range(65536)));
			write_reg(CFG_THRESHOLD, 17'($urandom_range(30000, 65536)));
			write_reg(CFG_SCALE, 17'($urandom_range(16384)));
			write_reg(CFG_PREFIX_LIM, 17'($urandom_range(15)));
			no_idle = (ph == 1);
			for (int i = 0; i < 10; i++) add_random_pair(i == 0 ? MAX_LEN + 2 : 12);
			wait_drained();
		end
		no_idle = 0;

		if (mismatches == 0 && expected_scores.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#20ms;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
`default_nettype wire
